[sv/genotype_group_statistics_macros.svh]
// Assertion macros shared by the block's modules.
`ifndef GENOTYPE_GROUP_STATISTICS_MACROS_SVH
`define GENOTYPE_GROUP_STATISTICS_MACROS_SVH
`ifndef ASSERT_OFF
`define GGS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GGS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GGS_ASSERT(lbl, clk, rst, prop, msg)
`define GGS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/ggs_pkg.sv]
package ggs_pkg;
  localparam int MAX_SAMPLES_LOG2 = 20;
  localparam int FRAC_BITS = 16;
  localparam int PREC_INT_BITS = 10;

  localparam int N_W = MAX_SAMPLES_LOG2 + 1;
  localparam int S_W = MAX_SAMPLES_LOG2 + 2;
  localparam int Q_W = MAX_SAMPLES_LOG2 + 3;
  localparam int DEV_W = N_W + Q_W;
  localparam int NUM_W = 2 * N_W;
  localparam int DQ_W = NUM_W + 2 * FRAC_BITS;
  localparam int ROOT_W = FRAC_BITS + PREC_INT_BITS;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int SREM_W = ROOT_W + 2;
  localparam int MUL_W = Q_W;

  localparam int FREQ_W = 17;
  localparam int MEAN_W = 18;
  localparam int PREC_W = 27;
  localparam int COUNT_W = 21;
  localparam int STATUS_W = 2;

  localparam int MEAN_STEPS = S_W + FRAC_BITS;
  localparam int PDIV_STEPS = DQ_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int CNT_W = 7;

  localparam logic [1:0] CODE_MISSING = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_VAR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_ACC = 4'd1;
  localparam logic [3:0] OP_MLOAD = 4'd2;
  localparam logic [3:0] OP_DSTEP = 4'd3;
  localparam logic [3:0] OP_MUL_NQ = 4'd4;
  localparam logic [3:0] OP_MUL_SS = 4'd5;
  localparam logic [3:0] OP_MUL_NN = 4'd6;
  localparam logic [3:0] OP_PLOAD = 4'd7;
  localparam logic [3:0] OP_SQLOAD = 4'd8;
  localparam logic [3:0] OP_SQSTEP = 4'd9;
  localparam logic [3:0] OP_OUT = 4'd10;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic dev_zero;
    logic sat;
    logic out_full;
  } sts_t;

  function automatic logic [1:0] dose_of(input logic [1:0] code);
    case (code)
      2'd2: dose_of = 2'd1;
      2'd3: dose_of = 2'd2;
      default: dose_of = 2'd0;
    endcase
  endfunction

  function automatic logic [2:0] square_of(input logic [1:0] code);
    case (code)
      2'd2: square_of = 3'd1;
      2'd3: square_of = 3'd4;
      default: square_of = 3'd0;
    endcase
  endfunction
endpackage

[sv/ggs_in_if.sv]
interface ggs_in_if;
  logic valid;
  logic ready;
  logic [7:0] geno_byte;
  logic [3:0] keep_mask;
  logic last_in_group;
  modport source(output valid, geno_byte, keep_mask, last_in_group, input ready);
  modport sink(input valid, geno_byte, keep_mask, last_in_group, output ready);
endinterface

[sv/ggs_out_if.sv]
interface ggs_out_if;
  logic valid;
  logic ready;
  logic [ggs_pkg::FREQ_W-1:0] allele_freq;
  logic [ggs_pkg::MEAN_W-1:0] group_mean;
  logic [ggs_pkg::PREC_W-1:0] group_precision;
  logic [ggs_pkg::COUNT_W-1:0] called_count;
  logic [ggs_pkg::STATUS_W-1:0] status_code;
  modport source(output valid, allele_freq, group_mean, group_precision, called_count,
                 status_code, input ready);
  modport sink(input valid, allele_freq, group_mean, group_precision, called_count,
               status_code, output ready);
endinterface

[sv/ggs_ctrl.sv]
`include "genotype_group_statistics_macros.svh"
module ggs_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  input  ggs_pkg::sts_t sts,
  output ggs_pkg::cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MLOAD = 4'd1;
  localparam logic [3:0] S_MDIV = 4'd2;
  localparam logic [3:0] S_MUL0 = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_CHK = 4'd6;
  localparam logic [3:0] S_PDIV = 4'd7;
  localparam logic [3:0] S_SQLD = 4'd8;
  localparam logic [3:0] S_SQRT = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state, state_next;
  logic [ggs_pkg::CNT_W-1:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd.op = ggs_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = ggs_pkg::OP_ACC;
          if (in_last) state_next = S_MLOAD;
        end
      end
      S_MLOAD: begin
        cmd.op = ggs_pkg::OP_MLOAD;
        cnt_next = ggs_pkg::CNT_W'(ggs_pkg::MEAN_STEPS - 1);
        state_next = S_MDIV;
      end
      S_MDIV: begin
        cmd.op = ggs_pkg::OP_DSTEP;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) state_next = S_MUL0;
      end
      S_MUL0: begin
        cmd.op = ggs_pkg::OP_MUL_NQ;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.op = ggs_pkg::OP_MUL_SS;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.op = ggs_pkg::OP_MUL_NN;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.op = ggs_pkg::OP_PLOAD;
        cnt_next = ggs_pkg::CNT_W'(ggs_pkg::PDIV_STEPS - 1);
        if (sts.n_zero || sts.dev_zero || sts.sat) state_next = S_DONE;
        else state_next = S_PDIV;
      end
      S_PDIV: begin
        cmd.op = ggs_pkg::OP_DSTEP;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) state_next = S_SQLD;
      end
      S_SQLD: begin
        cmd.op = ggs_pkg::OP_SQLOAD;
        cnt_next = ggs_pkg::CNT_W'(ggs_pkg::SQRT_STEPS - 1);
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = ggs_pkg::OP_SQSTEP;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_full) begin
          cmd.op = ggs_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  `GGS_ASSERT(a_mdiv_exit, clk, rst, (state == S_MDIV && cnt == '0) |=> (state == S_MUL0), "mean divide overran")
  `GGS_ASSERT(a_done_exit, clk, rst, (state == S_DONE && !sts.out_full) |=> (state == S_IDLE), "result not issued")
  `GGS_ASSERT(a_chk_path, clk, rst, (state == S_CHK && sts.n_zero) |=> (state == S_DONE), "root run with no calls")
endmodule

[sv/ggs_dp.sv]
`include "genotype_group_statistics_macros.svh"
module ggs_dp (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] geno_byte,
  input  logic [3:0] keep_mask,
  input  ggs_pkg::cmd_t cmd,
  output ggs_pkg::sts_t sts,
  input  logic out_ready,
  output logic out_valid,
  output logic [ggs_pkg::FREQ_W-1:0] allele_freq,
  output logic [ggs_pkg::MEAN_W-1:0] group_mean,
  output logic [ggs_pkg::PREC_W-1:0] group_precision,
  output logic [ggs_pkg::COUNT_W-1:0] called_count,
  output logic [ggs_pkg::STATUS_W-1:0] status_code
);
  logic [ggs_pkg::N_W-1:0] called_total, n_acc;
  logic [ggs_pkg::S_W-1:0] dosage_sum, s_acc;
  logic [ggs_pkg::Q_W-1:0] square_sum, q_acc;
  logic overflow_seen, o_acc;

  logic [ggs_pkg::DEV_W-1:0] rem, divisor, rem_new;
  logic [ggs_pkg::DEV_W:0] rem_sh;
  logic [ggs_pkg::DQ_W-1:0] dq;
  logic quo_bit;

  logic [ggs_pkg::MUL_W-1:0] mul_a, mul_b;
  logic [2*ggs_pkg::MUL_W-1:0] product;
  logic [ggs_pkg::DEV_W-1:0] prod_a, prod_b, dev;
  logic [ggs_pkg::NUM_W-1:0] num;
  logic [ggs_pkg::MEAN_W-1:0] mean_r;

  logic [ggs_pkg::RAD_W-1:0] rad;
  logic [ggs_pkg::ROOT_W-1:0] root;
  logic [ggs_pkg::SREM_W-1:0] srem, srem_sh, trial;
  logic root_bit;

  always_comb begin
    n_acc = called_total;
    s_acc = dosage_sum;
    q_acc = square_sum;
    o_acc = overflow_seen;
    for (int k = 0; k < 4; k++) begin
      if (keep_mask[k] && geno_byte[2*k +: 2] != ggs_pkg::CODE_MISSING) begin
        if (n_acc[ggs_pkg::N_W-1]) begin
          o_acc = 1'b1;
        end else begin
          n_acc = n_acc + 1'b1;
          s_acc = s_acc + ggs_pkg::S_W'(ggs_pkg::dose_of(geno_byte[2*k +: 2]));
          q_acc = q_acc + ggs_pkg::Q_W'(ggs_pkg::square_of(geno_byte[2*k +: 2]));
        end
      end
    end
  end

  assign rem_sh = {rem, dq[ggs_pkg::DQ_W-1]};
  assign quo_bit = (rem_sh >= {1'b0, divisor});
  assign rem_new = quo_bit ? ggs_pkg::DEV_W'(rem_sh - {1'b0, divisor})
                           : rem_sh[ggs_pkg::DEV_W-1:0];

  assign srem_sh = {srem[ggs_pkg::SREM_W-3:0], rad[ggs_pkg::RAD_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign root_bit = (srem_sh >= trial);

  always_comb begin
    mul_a = ggs_pkg::MUL_W'(called_total);
    mul_b = square_sum;
    case (cmd.op)
      ggs_pkg::OP_MUL_SS: begin
        mul_a = ggs_pkg::MUL_W'(dosage_sum);
        mul_b = ggs_pkg::MUL_W'(dosage_sum);
      end
      ggs_pkg::OP_MUL_NN: begin
        mul_b = ggs_pkg::MUL_W'(called_total - 1'b1);
      end
      default: ;
    endcase
  end
  assign product = mul_a * mul_b;

  assign sts.n_zero = (called_total == '0);
  assign sts.dev_zero = (dev == '0);
  assign sts.sat = (ggs_pkg::DEV_W'(num[ggs_pkg::NUM_W-1:2*ggs_pkg::PREC_INT_BITS]) >= dev);
  assign sts.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      called_total <= '0;
      dosage_sum <= '0;
      square_sum <= '0;
      overflow_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == ggs_pkg::OP_OUT) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        ggs_pkg::OP_ACC: begin
          called_total <= n_acc;
          dosage_sum <= s_acc;
          square_sum <= q_acc;
          overflow_seen <= o_acc;
        end
        ggs_pkg::OP_OUT: begin
          called_total <= '0;
          dosage_sum <= '0;
          square_sum <= '0;
          overflow_seen <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ggs_pkg::OP_MLOAD: begin
        rem <= '0;
        divisor <= ggs_pkg::DEV_W'(called_total);
        dq <= {dosage_sum, {(ggs_pkg::DQ_W - ggs_pkg::S_W){1'b0}}};
      end
      ggs_pkg::OP_DSTEP: begin
        rem <= rem_new;
        dq <= {dq[ggs_pkg::DQ_W-2:0], quo_bit};
      end
      ggs_pkg::OP_MUL_NQ: begin
        prod_a <= product[ggs_pkg::DEV_W-1:0];
        mean_r <= dq[ggs_pkg::MEAN_W-1:0];
      end
      ggs_pkg::OP_MUL_SS: prod_b <= product[ggs_pkg::DEV_W-1:0];
      ggs_pkg::OP_MUL_NN: begin
        num <= product[ggs_pkg::NUM_W-1:0];
        dev <= prod_a - prod_b;
      end
      ggs_pkg::OP_PLOAD: begin
        rem <= '0;
        divisor <= dev;
        dq <= {num, {(2*ggs_pkg::FRAC_BITS){1'b0}}};
      end
      ggs_pkg::OP_SQLOAD: begin
        rad <= dq[ggs_pkg::RAD_W-1:0];
        root <= '0;
        srem <= '0;
      end
      ggs_pkg::OP_SQSTEP: begin
        rad <= {rad[ggs_pkg::RAD_W-3:0], 2'b00};
        srem <= root_bit ? srem_sh - trial : srem_sh;
        root <= {root[ggs_pkg::ROOT_W-2:0], root_bit};
      end
      ggs_pkg::OP_OUT: begin
        called_count <= called_total;
        if (called_total == '0) begin
          allele_freq <= '0;
          group_mean <= '0;
          group_precision <= '0;
          status_code <= ggs_pkg::ST_NONE;
        end else begin
          allele_freq <= mean_r[ggs_pkg::MEAN_W-1:1];
          group_mean <= mean_r;
          if (dev == '0) group_precision <= '0;
          else if (sts.sat) group_precision <= ggs_pkg::PREC_W'(1) << ggs_pkg::ROOT_W;
          else group_precision <= ggs_pkg::PREC_W'(root);
          if (overflow_seen) status_code <= ggs_pkg::ST_OVERFLOW;
          else if (dev == '0) status_code <= ggs_pkg::ST_ZERO_VAR;
          else status_code <= ggs_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  `GGS_ASSERT(a_no_overwrite, clk, rst, (cmd.op == ggs_pkg::OP_OUT) |-> (!out_valid || out_ready), "result overwritten")
  `GGS_ASSERT(a_clear_after, clk, rst, (cmd.op == ggs_pkg::OP_OUT) |=> (called_total == '0 && !overflow_seen), "state not cleared")
  `GGS_ASSERT(a_count_cap, clk, rst, !called_total[ggs_pkg::N_W-1] || (called_total[ggs_pkg::N_W-2:0] == '0), "count past cap")
endmodule

[sv/genotype_group_statistics.sv]
// Sequence: after a group's last item, the mean divide, the three products and a check
//   run, then the precision divide and square root; these two are skipped when no
//   genotype is called, the variance is zero or the precision saturates.
// Throughput: one item per cycle within a group; the closing divide, multiply
//   and square-root sequence blocks input until the result register is loaded.
// Reset: synchronous rst clears the accumulators, sequencer and result valid.
module genotype_group_statistics (
  input logic clk,
  input logic rst,
  ggs_in_if.sink geno,
  ggs_out_if.source stats
);
  ggs_pkg::cmd_t cmd;
  ggs_pkg::sts_t sts;

  ggs_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(geno.valid),
    .in_last(geno.last_in_group),
    .in_ready(geno.ready),
    .sts(sts),
    .cmd(cmd)
  );

  ggs_dp u_dp (
    .clk(clk),
    .rst(rst),
    .geno_byte(geno.geno_byte),
    .keep_mask(geno.keep_mask),
    .cmd(cmd),
    .sts(sts),
    .out_ready(stats.ready),
    .out_valid(stats.valid),
    .allele_freq(stats.allele_freq),
    .group_mean(stats.group_mean),
    .group_precision(stats.group_precision),
    .called_count(stats.called_count),
    .status_code(stats.status_code)
  );
endmodule
